### rtl/spf_pkg.sv
package spf_pkg;

    // crc-16 polynomial, msb first, zero init
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // item codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_WR     = 2'd1;
    localparam logic [1:0] KIND_RD     = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // transfer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITE,
        PH_READ,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    // input beat
    typedef struct packed {
        logic        action;
        logic        is_read;
        logic [10:0] address;
        logic [8:0]  count;
        logic [7:0]  byte_value;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       crc_ok;
        logic       last;
    } t_out_item;

    // all beats caused by one input item, oldest in b0
    typedef struct packed {
        logic [1:0] n;
        t_out_item  b0;
        t_out_item  b1;
        t_out_item  b2;
    } t_burst;

    // one byte through the crc, unrolled over its 8 bits
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### rtl/spf_ctrl.sv
module spf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  spf_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_space,
    output logic              o_load,
    output spf_pkg::t_burst   o_burst
);

    logic              r_valid;
    spf_pkg::t_in_item r_item;
    spf_pkg::t_phase   r_phase, n_phase;
    logic [8:0]        r_left, n_left;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;

    logic [7:0]  hdr0, hdr1, hdr2;
    logic [15:0] hdr_crc;
    logic [8:0]  left_dec;
    logic        consume;

    // header bytes and their crc
    assign hdr0     = r_item.address[7:0];
    assign hdr1     = {r_item.is_read, r_item.count[8], 3'b000, r_item.address[10:8]};
    assign hdr2     = r_item.count[7:0];
    assign hdr_crc  = spf_pkg::crc_byte(spf_pkg::crc_byte(spf_pkg::crc_byte(16'h0000,
                          hdr0), hdr1), hdr2);
    assign left_dec = r_left - 9'd1;

    // held item leaves once the output side can take all of its beats
    assign consume = r_valid && ((o_burst.n == 2'd0) || i_space);
    assign o_stall = r_valid && !consume;
    assign o_load  = consume && (o_burst.n != 2'd0);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= spf_pkg::PH_IDLE;
            r_left   <= '0;
            r_crc    <= '0;
            r_crc_lo <= '0;
        end else if (consume) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        if (r_item.action == spf_pkg::ACT_START) begin
            n_crc    = hdr_crc;
            n_crc_lo = '0;
            n_left   = r_item.count;
            if (r_item.is_read) begin
                n_phase = (r_item.count != '0) ? spf_pkg::PH_READ : spf_pkg::PH_CRC_LO;
            end else begin
                n_phase = (r_item.count != '0) ? spf_pkg::PH_WRITE : spf_pkg::PH_IDLE;
            end
        end else begin
            case (r_phase)
                spf_pkg::PH_WRITE: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = spf_pkg::PH_IDLE;
                    end
                end
                spf_pkg::PH_READ: begin
                    n_crc  = spf_pkg::crc_byte(r_crc, r_item.byte_value);
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = spf_pkg::PH_CRC_LO;
                    end
                end
                spf_pkg::PH_CRC_LO: begin
                    n_crc_lo = r_item.byte_value;
                    n_phase  = spf_pkg::PH_CRC_HI;
                end
                spf_pkg::PH_CRC_HI: begin
                    n_phase = spf_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = spf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // beats for the held item
    always_comb begin
        o_burst = '0;
        if (r_item.action == spf_pkg::ACT_START) begin
            o_burst.n  = 2'd3;
            o_burst.b0 = '{kind: spf_pkg::KIND_HDR, out_byte: hdr0, crc_ok: 1'b0, last: 1'b0};
            o_burst.b1 = '{kind: spf_pkg::KIND_HDR, out_byte: hdr1, crc_ok: 1'b0, last: 1'b0};
            o_burst.b2 = '{kind: spf_pkg::KIND_HDR, out_byte: hdr2, crc_ok: 1'b0, last: 1'b1};
        end else begin
            case (r_phase)
                spf_pkg::PH_WRITE: begin
                    o_burst.n  = 2'd1;
                    o_burst.b0 = '{kind: spf_pkg::KIND_WR, out_byte: r_item.byte_value,
                                   crc_ok: 1'b0, last: 1'b1};
                end
                spf_pkg::PH_READ: begin
                    o_burst.n  = 2'd1;
                    o_burst.b0 = '{kind: spf_pkg::KIND_RD, out_byte: r_item.byte_value,
                                   crc_ok: 1'b0, last: 1'b1};
                end
                spf_pkg::PH_CRC_HI: begin
                    o_burst.n  = 2'd1;
                    o_burst.b0 = '{kind: spf_pkg::KIND_STATUS, out_byte: 8'h00,
                                   crc_ok: ({r_item.byte_value, r_crc_lo} == r_crc),
                                   last: 1'b1};
                end
                default: begin
                    o_burst.n = 2'd0;
                end
            endcase
        end
    end

endmodule

### rtl/spf_out.sv
module spf_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  spf_pkg::t_burst    i_burst,
    output logic               o_space,
    output logic               o_valid,
    output spf_pkg::t_out_item o_data,
    input  logic               i_stall
);

    logic [1:0]         r_cnt;
    spf_pkg::t_out_item r_beat [3];
    logic               pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_beat[0];
    assign pop     = o_valid && !i_stall;
    // room for a new burst once the last held beat leaves
    assign o_space = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);

    // beat count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // beat shift line
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat[0] <= i_burst.b0;
            r_beat[1] <= i_burst.b1;
            r_beat[2] <= i_burst.b2;
        end else if (pop) begin
            r_beat[0] <= r_beat[1];
            r_beat[1] <= r_beat[2];
        end
    end

endmodule

### rtl/spi_frame_crc16_engine_core.sv
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_in_data  (spf_pkg::t_in_item)
// out     | o_out_valid| i_out_stall | o_out_data (spf_pkg::t_out_item)
//
// a byte beat is taken every cycle while the output does not stall; a start beat
// puts out three header beats, one per cycle unless the output stalls, so the input stalls behind it
// first result beat passes through the input register, then the three-entry
// output shift line
// reset is synchronous and active low: transfer goes idle, both stages empty
// output stall backs up into the input register and then into o_in_stall
module spi_frame_crc16_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  spf_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output spf_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic            space;
    logic            load;
    spf_pkg::t_burst burst;

    spf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_stall (o_in_stall),
        .i_space (space),
        .o_load  (load),
        .o_burst (burst)
    );

    spf_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_space (space),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // a burst is only loaded while the output line has room
    a_load_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> space)
        else $error("burst loaded over held beats");

    // status beats close their item and carry no byte
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == spf_pkg::KIND_STATUS))
            |-> (o_out_data.last && (o_out_data.out_byte == 8'h00)))
        else $error("malformed status beat");

    // crc flag only on status beats
    a_crc_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.crc_ok) |-> (o_out_data.kind == spf_pkg::KIND_STATUS))
        else $error("crc flag on data beat");

    // header beats come as three with last on the third only
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (burst.n == 2'd3)) |-> (!burst.b0.last && !burst.b1.last && burst.b2.last))
        else $error("header burst last marking wrong");

endmodule
